// ----- rtl/dgsp_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dgsp_pkg
// Shared types and constants for the dense graph shortest path block.
// ----------------------------------------------------------------------------
package dgsp_pkg;

	localparam int MAX_VERTEX_COUNT = 64;
	localparam int VERT_W           = 6;
	localparam int COUNT_W          = 7;
	localparam int DIST_W           = 20;
	localparam int WEIGHT_W         = 13;
	localparam int ADJ_AW           = 2 * VERT_W;
	localparam int DIST_DEPTH       = 1 << VERT_W;
	localparam int ADJ_DEPTH        = 1 << ADJ_AW;
	localparam int CFG_IDX_W        = 1;

	localparam logic [COUNT_W-1:0] MAX_COUNT   = COUNT_W'(MAX_VERTEX_COUNT);
	localparam logic [DIST_W-1:0]  UNREACHABLE = DIST_W'(999999);

	localparam logic [CFG_IDX_W-1:0] CFG_START_VERTEX = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_VERTEX_COUNT = 1'b1;

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_PASS,
		ST_GAP
	} state_t;

	// one slot of a sweep over the distance store
	typedef struct packed {
		logic              valid;
		logic              init;
		logic              emit;
		logic              last_elem;
		logic [VERT_W-1:0] idx;
	} issue_t;

endpackage
`default_nettype wire

// ----- rtl/dgsp_relax.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dgsp_relax
// Distance store with read-modify-write sweep: initialises or relaxes each
// vertex, tracks the closest unsettled vertex for the next round and
// registers the result words on the final sweep.
// ----------------------------------------------------------------------------
module dgsp_relax (
	input  wire                           clk,
	input  wire                           arst_n,
	input  wire dgsp_pkg::issue_t         ctl,
	input  wire [dgsp_pkg::VERT_W-1:0]    start_vertex,
	input  wire [dgsp_pkg::WEIGHT_W-1:0]  adj_s1,
	output logic [dgsp_pkg::VERT_W-1:0]   pick_u,
	output logic                          result_valid,
	output logic [dgsp_pkg::VERT_W-1:0]   vertex,
	output logic [dgsp_pkg::DIST_W-1:0]   distance,
	output logic                          final_res
);
	import dgsp_pkg::*;

	// entry: {settled, distance}
	logic [DIST_W:0]   dist_mem [DIST_DEPTH];
	logic [DIST_W:0]   rd_s1;
	issue_t            ctl_s1;

	logic [VERT_W-1:0] u_q;
	logic [DIST_W-1:0] du_q;
	logic [DIST_W-1:0] best_q;
	logic [VERT_W-1:0] pick_q;

	logic              old_set;
	logic [DIST_W-1:0] old_d;
	logic [DIST_W:0]   sum;
	logic              relax;
	logic              new_set;
	logic [DIST_W-1:0] new_d;
	logic [DIST_W-1:0] base_best;
	logic [VERT_W-1:0] base_pick;
	logic              cand;
	logic [DIST_W-1:0] best_n;
	logic [VERT_W-1:0] pick_n;

	always_ff @(posedge clk) begin
		rd_s1 <= dist_mem[ctl.idx];
		if (ctl_s1.valid) begin
			dist_mem[ctl_s1.idx] <= {new_set, new_d};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
		end else begin
			ctl_s1 <= ctl;
		end
	end

	always_comb begin
		old_set = rd_s1[DIST_W];
		old_d   = rd_s1[DIST_W-1:0];
		sum     = {1'b0, du_q} + {{(DIST_W+1-WEIGHT_W){1'b0}}, adj_s1};
		relax   = !old_set && (ctl_s1.idx != u_q) && (adj_s1 != '0)
			&& (du_q != UNREACHABLE) && (sum < {1'b0, old_d});
		if (ctl_s1.init) begin
			new_set = 1'b0;
			new_d   = (ctl_s1.idx == start_vertex) ? '0 : UNREACHABLE;
		end else begin
			new_set = old_set || (ctl_s1.idx == u_q);
			new_d   = relax ? sum[DIST_W-1:0] : old_d;
		end
		// tracker restarts with each sweep; ties go to the higher index
		base_best = (ctl_s1.idx == '0) ? UNREACHABLE : best_q;
		base_pick = (ctl_s1.idx == '0) ? '0 : pick_q;
		cand      = !new_set && (new_d <= base_best);
		best_n    = cand ? new_d : base_best;
		pick_n    = cand ? ctl_s1.idx : base_pick;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			best_q <= UNREACHABLE;
			pick_q <= '0;
			u_q    <= '0;
			du_q   <= UNREACHABLE;
		end else if (ctl_s1.valid) begin
			best_q <= best_n;
			pick_q <= pick_n;
			if (ctl_s1.last_elem) begin
				u_q  <= pick_n;
				du_q <= best_n;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
		end else begin
			result_valid <= ctl_s1.valid && ctl_s1.emit;
		end
	end

	always_ff @(posedge clk) begin
		vertex    <= ctl_s1.idx;
		distance  <= new_d;
		final_res <= ctl_s1.last_elem;
	end

	assign pick_u = u_q;

endmodule
`default_nettype wire

// ----- rtl/dense_graph_shortest_paths.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dense_graph_shortest_paths
// Single-source shortest paths over a dense adjacency matrix.
//
// Load: each start pulse with busy low writes one matrix word (row, column,
// weight; weight zero is no edge), so words load back to back.
// A word with last high also starts a run over n = min(vertex_count, 64)
// vertices from start_vertex. The run makes n sweeps over the distance
// store, one vertex per cycle (one read-modify-write port):
// an initial sweep, then one sweep per round that relaxes the settled
// vertex's edges while finding the next closest vertex.
// Results: the last sweep emits one word per vertex in order, on
// consecutive cycles, with result_valid high for one cycle each and
// final_res on the last; the receiver cannot stall them.
// After every run, and after reset, the matrix store is zeroed in a sweep
// over all 4096 words; busy stays high from a run's start to the end of
// that sweep.
// Config writes (cfg_valid/cfg_ready) are always accepted.
// ----------------------------------------------------------------------------
module dense_graph_shortest_paths (
	input  wire                            clk,
	input  wire                            arst_n,
	input  wire                            start,
	output logic                           busy,
	input  wire [dgsp_pkg::VERT_W-1:0]     row,
	input  wire [dgsp_pkg::VERT_W-1:0]     column,
	input  wire [dgsp_pkg::WEIGHT_W-1:0]   weight,
	input  wire                            last,
	input  wire                            cfg_valid,
	output logic                           cfg_ready,
	input  wire [dgsp_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire [dgsp_pkg::COUNT_W-1:0]    cfg_data,
	output logic                           result_valid,
	output logic [dgsp_pkg::VERT_W-1:0]    vertex,
	output logic [dgsp_pkg::DIST_W-1:0]    distance,
	output logic                           final_res
);
	import dgsp_pkg::*;

	state_t              state_q, state_n;
	logic [ADJ_AW-1:0]   clr_q, clr_n;
	logic [VERT_W-1:0]   idx_q, idx_n;
	logic [VERT_W-1:0]   pass_q, pass_n;
	logic [COUNT_W-1:0]  n_q, n_n;
	logic [VERT_W-1:0]   start_q;
	logic [COUNT_W-1:0]  count_q;

	logic [WEIGHT_W-1:0] adj_mem [ADJ_DEPTH];
	logic [WEIGHT_W-1:0] adj_s1;
	logic                adj_we;
	logic [ADJ_AW-1:0]   adj_waddr;
	logic [WEIGHT_W-1:0] adj_wdata;
	logic [VERT_W-1:0]   pick_u;

	logic [COUNT_W-1:0]  n_sat;
	logic [COUNT_W-1:0]  n_m1;
	logic                last_pass;
	issue_t              ctl;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q <= '0;
			count_q <= MAX_COUNT;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_START_VERTEX: start_q <= cfg_data[VERT_W-1:0];
				CFG_VERTEX_COUNT: count_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (adj_we) begin
			adj_mem[adj_waddr] <= adj_wdata;
		end
		adj_s1 <= adj_mem[{pick_u, idx_q}];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			clr_q   <= '0;
			idx_q   <= '0;
			pass_q  <= '0;
			n_q     <= '0;
		end else begin
			state_q <= state_n;
			clr_q   <= clr_n;
			idx_q   <= idx_n;
			pass_q  <= pass_n;
			n_q     <= n_n;
		end
	end

	always_comb begin
		n_sat     = (count_q > MAX_COUNT) ? MAX_COUNT : count_q;
		n_m1      = n_q - COUNT_W'(1);
		last_pass = (pass_q == n_m1[VERT_W-1:0]);

		state_n   = state_q;
		clr_n     = clr_q;
		idx_n     = idx_q;
		pass_n    = pass_q;
		n_n       = n_q;
		busy      = 1'b1;
		adj_we    = 1'b0;
		adj_waddr = clr_q;
		adj_wdata = '0;
		ctl       = '0;

		case (state_q)
			ST_CLEAR: begin
				adj_we = 1'b1;
				clr_n  = clr_q + ADJ_AW'(1);
				if (clr_q == '1) begin
					state_n = ST_IDLE;
				end
			end
			ST_IDLE: begin
				busy = 1'b0;
				if (start) begin
					adj_we    = 1'b1;
					adj_waddr = {row, column};
					adj_wdata = weight;
					if (last) begin
						n_n    = n_sat;
						idx_n  = '0;
						pass_n = '0;
						clr_n  = '0;
						state_n = (n_sat == '0) ? ST_CLEAR : ST_PASS;
					end
				end
			end
			ST_PASS: begin
				ctl.valid     = 1'b1;
				ctl.init      = (pass_q == '0);
				ctl.emit      = last_pass;
				ctl.last_elem = (idx_q == n_m1[VERT_W-1:0]);
				ctl.idx       = idx_q;
				if (ctl.last_elem) begin
					state_n = ST_GAP;
				end else begin
					idx_n = idx_q + VERT_W'(1);
				end
			end
			ST_GAP: begin
				idx_n = '0;
				if (last_pass) begin
					clr_n   = '0;
					state_n = ST_CLEAR;
				end else begin
					pass_n  = pass_q + VERT_W'(1);
					state_n = ST_PASS;
				end
			end
			default: begin
				state_n = ST_CLEAR;
				clr_n   = '0;
			end
		endcase
	end

	dgsp_relax u_relax (
		.clk          (clk),
		.arst_n       (arst_n),
		.ctl          (ctl),
		.start_vertex (start_q),
		.adj_s1       (adj_s1),
		.pick_u       (pick_u),
		.result_valid (result_valid),
		.vertex       (vertex),
		.distance     (distance),
		.final_res    (final_res)
	);

endmodule
`default_nettype wire

// ----- rtl/dgsp_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dgsp_checker
// Port-level checks on the result sequence and busy behaviour.
// ----------------------------------------------------------------------------
module dgsp_checker (
	input wire                           clk,
	input wire                           arst_n,
	input wire                           start,
	input wire                           busy,
	input wire                           last,
	input wire                           result_valid,
	input wire [dgsp_pkg::VERT_W-1:0]    vertex,
	input wire                           final_res
);
	import dgsp_pkg::*;

	a_result_in_run: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> busy)
		else $error("result word outside a run");

	a_results_contiguous: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !final_res |=> result_valid && (vertex == $past(vertex) + VERT_W'(1)))
		else $error("result words not in consecutive vertex order");

	a_final_ends: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && final_res |=> !result_valid)
		else $error("result word after final");

	a_run_goes_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && last |=> busy)
		else $error("run did not start");

	a_load_stays_idle: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && !last |=> !busy)
		else $error("plain load word left the block busy");

endmodule

bind dense_graph_shortest_paths dgsp_checker u_dgsp_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.start        (start),
	.busy         (busy),
	.last         (last),
	.result_valid (result_valid),
	.vertex       (vertex),
	.final_res    (final_res)
);
`default_nettype wire
